[rtl/core/tar_pkg.sv]
// shared types and constants of the tensor axis reduction block
`default_nettype none

package tar_pkg;

  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned MAX_GROUP   = 65536;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ELEM_W      = 32;
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned POS_W       = 16;

  typedef enum logic [FUNC_W-1:0] {
    OP_SUM    = 3'd0,
    OP_MAX    = 3'd1,
    OP_MIN    = 3'd2,
    OP_ARGMAX = 3'd3,
    OP_ARGMIN = 3'd4
  } op_e;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic [FUNC_W-1:0]        func;
    logic                     last_of_group;
  } in_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] reduced_value;
    logic [POS_W-1:0]         best_position;
  } out_t;

  // classification of one element, handed from front to back
  typedef struct packed {
    logic             first;
    logic             last;
    op_e              op;
    logic [POS_W-1:0] pos;
  } ctrl_t;

endpackage

`default_nettype wire

[rtl/core/tar_fifo.sv]
// small register queue with first-word-fall-through read
`default_nettype none

module tar_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = tar_pkg::QUEUE_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire T     wdata_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          rdata_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  T              mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tar_front.sv]
// front end: takes elements, tracks group position and latches the group operation
`default_nettype none

module tar_front #(
  parameter int unsigned DATA_WIDTH = tar_pkg::DATA_WIDTH,
  parameter int unsigned MAX_GROUP  = tar_pkg::MAX_GROUP
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire tar_pkg::in_t in_i,
  input  wire logic         push_i,
  output logic              full_o,
  output logic              item_valid_o,
  input  wire logic         item_ready_i,
  output tar_pkg::ctrl_t    item_ctrl_o,
  output logic signed [DATA_WIDTH-1:0] item_value_o
);

  localparam int unsigned CntW = $clog2(MAX_GROUP);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_GROUP - 1);

  logic [CntW-1:0] count_q, count_d;
  tar_pkg::op_e    op_q, op_d;
  logic            accept, first;
  logic signed [63:0] elem_ext;

  assign full_o       = !item_ready_i;
  assign item_valid_o = push_i;
  assign accept       = push_i && item_ready_i;
  assign first        = (count_q == '0);

  // element taken as DATA_WIDTH-bit two's complement
  assign elem_ext     = 64'(in_i.element);
  assign item_value_o = elem_ext[DATA_WIDTH-1:0];

  always_comb begin
    item_ctrl_o.first = first;
    item_ctrl_o.last  = in_i.last_of_group;
    item_ctrl_o.op    = first ? tar_pkg::op_e'(in_i.func) : op_q;
    item_ctrl_o.pos   = tar_pkg::POS_W'(count_q);
  end

  always_comb begin
    count_d = count_q;
    op_d    = op_q;
    if (accept) begin
      if (first) begin
        op_d = tar_pkg::op_e'(in_i.func);
      end
      if (in_i.last_of_group) begin
        count_d = '0;
      end else if (count_q != MaxCnt) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      op_q    <= tar_pkg::OP_SUM;
    end else begin
      count_q <= count_d;
      op_q    <= op_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tar_back.sv]
// back end: accumulator for sum, max, min and the arg operations
`default_nettype none

module tar_back #(
  parameter int unsigned DATA_WIDTH = tar_pkg::DATA_WIDTH
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  output logic                item_ready_o,
  input  wire tar_pkg::ctrl_t item_ctrl_i,
  input  wire logic signed [DATA_WIDTH-1:0] item_value_i,
  output logic                res_valid_o,
  input  wire logic           res_full_i,
  output tar_pkg::out_t       res_o
);

  logic signed [DATA_WIDTH-1:0]  run_q, run_d;
  logic [tar_pkg::POS_W-1:0]     best_q, best_d;
  logic signed [63:0]            run_ext;
  logic                          take, is_arg, op_known;

  // a group end waits for room in the result queue
  assign item_ready_o = !(item_ctrl_i.last && res_full_i);
  assign take         = item_valid_i && item_ready_o;
  assign res_valid_o  = take && item_ctrl_i.last;

  assign is_arg   = (item_ctrl_i.op == tar_pkg::OP_ARGMAX) ||
                    (item_ctrl_i.op == tar_pkg::OP_ARGMIN);
  assign op_known = (item_ctrl_i.op == tar_pkg::OP_SUM) ||
                    (item_ctrl_i.op == tar_pkg::OP_MAX) ||
                    (item_ctrl_i.op == tar_pkg::OP_MIN) || is_arg;

  always_comb begin
    run_d  = run_q;
    best_d = best_q;
    if (item_ctrl_i.first) begin
      run_d  = op_known ? item_value_i : '0;
      best_d = '0;
    end else begin
      unique case (item_ctrl_i.op)
        tar_pkg::OP_SUM: begin
          run_d = run_q + item_value_i;
        end
        tar_pkg::OP_MAX, tar_pkg::OP_ARGMAX: begin
          if (run_q < item_value_i) begin
            run_d  = item_value_i;
            best_d = item_ctrl_i.pos;
          end
        end
        tar_pkg::OP_MIN, tar_pkg::OP_ARGMIN: begin
          if (item_value_i < run_q) begin
            run_d  = item_value_i;
            best_d = item_ctrl_i.pos;
          end
        end
        default: begin
          run_d = run_q;
        end
      endcase
    end
  end

  assign run_ext = 64'(run_d);

  always_comb begin
    res_o.reduced_value = run_ext[tar_pkg::ELEM_W-1:0];
    res_o.best_position = is_arg ? best_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      best_q <= '0;
    end else if (take) begin
      run_q  <= run_d;
      best_q <= best_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tensor_axis_reduction.sv]
// top level of the streaming axis reduction: front end, item queue, back end, result queue
//
// usage
//   input channel: drive in_i and raise push_i; a transaction completes at a
//   rising edge with push_i high and full_o low. in_i.func of the first element
//   selects the group operation (sum, max, min, argmax, argmin); later codes are
//   ignored. in_i.last_of_group closes the group.
//   result channel: while empty_o is low, out_o shows the oldest result; it is
//   removed at a rising edge with pop_i high. one result per closed group.
// timing
//   one element per cycle while full_o is low; the front end classifies an
//   element in the cycle it arrives and writes it into the item queue, and the
//   back end folds it into the single accumulator once it heads that queue; a
//   result enters the result queue when the back end takes the group's last element.
// stall behavior
//   a stalled result channel fills the result queue, then the back end holds its
//   group end, then the item queue fills and full_o rises. both queues hold
//   QUEUE_DEPTH entries, so the front keeps taking elements for a while.
// reset
//   rst_ni low empties both queues and clears the group position and
//   accumulator; full_o is low and empty_o high right after reset.
`default_nettype none

module tensor_axis_reduction #(
  parameter int unsigned DATA_WIDTH  = tar_pkg::DATA_WIDTH,
  parameter int unsigned MAX_GROUP   = tar_pkg::MAX_GROUP,
  parameter int unsigned QUEUE_DEPTH = tar_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tar_pkg::in_t  in_i,
  input  wire logic          push_i,
  output logic               full_o,
  output tar_pkg::out_t      out_o,
  output logic               empty_o,
  input  wire logic          pop_i
);

  // element plus its classification, queued between front and back
  typedef struct packed {
    tar_pkg::ctrl_t               ctrl;
    logic signed [DATA_WIDTH-1:0] value;
  } qitem_t;

  qitem_t        front_item, back_item;
  logic          front_valid, mid_full;
  logic          mid_empty, back_ready;
  logic          res_valid, res_full;
  tar_pkg::out_t res_data;

  tar_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_GROUP  (MAX_GROUP)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_i       (push_i),
    .full_o       (full_o),
    .item_valid_o (front_valid),
    .item_ready_i (!mid_full),
    .item_ctrl_o  (front_item.ctrl),
    .item_value_o (front_item.value)
  );

  // item queue between classification and accumulation
  tar_fifo #(
    .T     (qitem_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .wdata_i (front_item),
    .full_o  (mid_full),
    .pop_i   (back_ready),
    .rdata_o (back_item),
    .empty_o (mid_empty)
  );

  tar_back #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!mid_empty),
    .item_ready_o (back_ready),
    .item_ctrl_i  (back_item.ctrl),
    .item_value_i (back_item.value),
    .res_valid_o  (res_valid),
    .res_full_i   (res_full),
    .res_o        (res_data)
  );

  // result queue decouples the accumulator from the receiver
  tar_fifo #(
    .T     (tar_pkg::out_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .wdata_i (res_data),
    .full_o  (res_full),
    .pop_i   (pop_i),
    .rdata_o (out_o),
    .empty_o (empty_o)
  );

endmodule

`default_nettype wire

[rtl/core/tar_checker.sv]
// port-level checker for the axis reduction, bound to the top level
`default_nettype none

module tar_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire tar_pkg::in_t  in_i,
  input wire logic          push_i,
  input wire logic          full_o,
  input wire tar_pkg::out_t out_o,
  input wire logic          empty_o,
  input wire logic          pop_i
);

  // closed groups whose result has not been taken yet
  logic [7:0] pending_q, pending_d;
  logic       grp_end, res_take;

  assign grp_end  = push_i && !full_o && in_i.last_of_group;
  assign res_take = pop_i && !empty_o;

  always_comb begin
    pending_d = pending_q;
    if (grp_end && !res_take) begin
      pending_d = pending_q + 1'b1;
    end else if (res_take && !grp_end) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_no_phantom_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (pending_q != '0))
    else $error("result shown without a closed group");

  a_empty_after_reset: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> (empty_o && !full_o))
    else $error("queues not empty after reset");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(out_o)))
    else $error("waiting result changed or vanished");

endmodule

bind tensor_axis_reduction tar_checker u_tar_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .in_i    (in_i),
  .push_i  (push_i),
  .full_o  (full_o),
  .out_o   (out_o),
  .empty_o (empty_o),
  .pop_i   (pop_i)
);

`default_nettype wire
